>>> design/assert_macros.svh
// Assertion macros used by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALL(label, clk, prop, msg)
`endif
`endif

>>> design/wtdf_pkg.sv
// Constants and state codes of the wheel trial division factorizer.
package wtdf_pkg;
    localparam int VALUE_WIDTH = 31;
    localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
    localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NONE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;
    localparam logic [2:0] ST_REST  = 3'd5;
    localparam logic [2:0] ST_FINAL = 3'd6;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [DIV_WIDTH-1:0]   divisor_t;
endpackage

>>> design/wheel_trial_division_factorizer.sv
// Top level: prime factorization by trial division over a wheel of 6.
//
// Usage: one beat on the s_ channel carries the number to factor in
// s_tdata[30:0]. The block answers with its prime factors in ascending
// order, one m_ beat per factor, repeats included; m_tlast marks the final
// beat. An input of 0 or 1 gives one beat with factor 0, m_tlast high and
// m_tuser (no factor) high.
// Throughput: one number at a time; s_tready is high only while idle.
// Every trial is a bit-serial restoring division of the remaining value by
// the divisor, one quotient bit a cycle, then a check of the remainder.
// Divisors are 2, 3, then 6k-1 and 6k+1; the search stops once a 6k-1
// divisor exceeds its quotient. A prime near 2^31 takes about 15.5k
// trials. Each factor is held back one step so that the last one can be
// marked. Reset (aresetn low, synchronous) returns to idle and drops any
// beat in the output register. A stalled receiver holds the m_ beat in
// the output register; the trials go on, and the block waits only when
// it has a further beat to send.
module wheel_trial_division_factorizer
    import wtdf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_WIDTH-1:0] s_tdata,   // [30:0] number
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_WIDTH-1:0] m_tdata,   // [30:0] factor
    output logic                   m_tlast,
    output logic                   m_tuser    // [0] no_factor
);
`include "assert_macros.svh"

    logic [2:0]           state_reg, state_next;
    value_t               rem_reg, rem_next;       // remaining value
    value_t               quo_reg, quo_next;       // dividend / quotient shifter
    divisor_t             part_reg, part_next;     // partial remainder
    divisor_t             div_reg, div_next;       // trial divisor
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 wheel_lo_reg, wheel_lo_next; // divisor is 6k-1
    logic                 first_reg, first_next;       // first trial of a 6k-1 divisor
    value_t               fac_reg, fac_next;       // factor waiting to be pushed
    logic                 push_end_reg, push_end_next; // after push go to final
    value_t               pend_reg, pend_next;     // held-back factor
    logic                 pend_vld_reg, pend_vld_next;
    logic                 out_vld_reg, out_vld_next;
    value_t               out_fac_reg, out_fac_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_none_reg, out_none_next;

    logic                 out_free;
    logic [DIV_WIDTH:0]   shifted;
    logic [DIV_WIDTH:0]   diff;
    value_t               div_wide;

    assign out_free = !out_vld_reg || m_tready;
    assign shifted  = {part_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff     = shifted - {1'b0, div_reg};
    assign div_wide = value_t'(div_reg);

    always_comb begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        part_next     = part_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        wheel_lo_next = wheel_lo_reg;
        first_next    = first_reg;
        fac_next      = fac_reg;
        push_end_next = push_end_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_fac_next  = out_fac_reg;
        out_last_next = out_last_reg;
        out_none_next = out_none_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next      = s_tdata[VALUE_WIDTH-1:0];
                    quo_next      = s_tdata[VALUE_WIDTH-1:0];
                    part_next     = '0;
                    cnt_next      = '0;
                    div_next      = divisor_t'(2);
                    wheel_lo_next = 1'b0;
                    first_next    = 1'b0;
                    pend_vld_next = 1'b0;
                    if (s_tdata[VALUE_WIDTH-1:1] == '0) begin
                        state_next = ST_NONE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_fac_next  = '0;
                    out_last_next = 1'b1;
                    out_none_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV: begin
                // One restoring step: take the divisor off if it fits.
                if (!diff[DIV_WIDTH]) begin
                    part_next = diff[DIV_WIDTH-1:0];
                end else begin
                    part_next = shifted[DIV_WIDTH-1:0];
                end
                quo_next = {quo_reg[VALUE_WIDTH-2:0], !diff[DIV_WIDTH]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                first_next = 1'b0;
                part_next  = '0;
                cnt_next   = '0;
                if (first_reg && (div_wide > quo_reg)) begin
                    // Divisor squared exceeds the remaining value: stop.
                    state_next = ST_REST;
                end else if (part_reg == '0) begin
                    rem_next      = quo_reg;
                    fac_next      = div_wide;
                    push_end_next = 1'b0;
                    state_next    = ST_PUSH;
                end else begin
                    // Advance along 2, 3, 5, 7, 11, 13, ...
                    quo_next   = rem_reg;
                    state_next = ST_DIV;
                    if (div_reg == divisor_t'(2)) begin
                        div_next = divisor_t'(3);
                    end else if (div_reg == divisor_t'(3)) begin
                        div_next      = divisor_t'(5);
                        wheel_lo_next = 1'b1;
                        first_next    = 1'b1;
                    end else if (wheel_lo_reg) begin
                        div_next      = div_reg + divisor_t'(2);
                        wheel_lo_next = 1'b0;
                    end else begin
                        div_next      = div_reg + divisor_t'(4);
                        wheel_lo_next = 1'b1;
                        first_next    = 1'b1;
                    end
                end
            end
            ST_PUSH: begin
                // Hold the new factor back; release the previous one.
                if (!pend_vld_reg || out_free) begin
                    if (pend_vld_reg) begin
                        out_vld_next  = 1'b1;
                        out_fac_next  = pend_reg;
                        out_last_next = 1'b0;
                        out_none_next = 1'b0;
                    end
                    pend_next     = fac_reg;
                    pend_vld_next = 1'b1;
                    quo_next      = rem_reg;
                    if (push_end_reg) begin
                        state_next = ST_FINAL;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_REST: begin
                if (rem_reg[VALUE_WIDTH-1:1] != '0) begin
                    fac_next      = rem_reg;
                    push_end_next = 1'b1;
                    state_next    = ST_PUSH;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_fac_next  = pend_reg;
                    out_last_next = 1'b1;
                    out_none_next = 1'b0;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            cnt_reg      <= cnt_next;
        end
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        part_reg     <= part_next;
        div_reg      <= div_next;
        wheel_lo_reg <= wheel_lo_next;
        first_reg    <= first_next;
        fac_reg      <= fac_next;
        push_end_reg <= push_end_next;
        pend_reg     <= pend_next;
        out_fac_reg  <= out_fac_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_WIDTH'(out_fac_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_none_reg;

    `ASSERT_RST(a_final_has_pend, aclk, aresetn, (state_reg == ST_FINAL) |-> pend_vld_reg, "final state without a held factor")
    `ASSERT_RST(a_div_nonzero, aclk, aresetn, (state_reg == ST_DIV) |-> (div_reg >= divisor_t'(2)), "trial divisor below two")
    `ASSERT_RST(a_cnt_idle, aclk, aresetn, (state_reg == ST_IDLE) |-> (cnt_reg == '0), "bit counter not cleared")
    `ASSERT_RST(a_none_last, aclk, aresetn, (m_tvalid && m_tuser) |-> m_tlast, "no-factor beat not last")
    `ASSERT_ALL(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE && !m_tvalid), "reset did not idle")
endmodule
